// ===== rtl/core/polar_angle_sort_about_pivot_unit_macros.svh =====
// Assertion macros for the polar angle sort top unit.
// Needs a clk_i clock and an active-low rst_ni reset in the including scope.
`ifndef POLAR_ANGLE_SORT_ABOUT_PIVOT_UNIT_MACROS_SVH
`define POLAR_ANGLE_SORT_ABOUT_PIVOT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PASAP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pasap assertion failed");
`define PASAP_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("pasap assertion failed");
`else
`define PASAP_ASSERT(lbl, prop)
`define PASAP_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== rtl/core/pasap_pkg.sv =====
// Package for the polar angle sort: default sizes, state codes, cell control.
// No dependencies.
`default_nettype none
package pasap_pkg;
  localparam int unsigned MaxPoints  = 64;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned IndexWidth = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_e;

  // Control handed from the sequencer to every cell
  typedef struct packed {
    logic prod_en;
    logic step;
    logic shift;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/polar_angle_sort_about_pivot_unit.sv =====
// Load: one point per cycle, pivot tracked as points arrive.
// Sort: 2*MAX_POINTS+4 steps through a row of MAX_POINTS cells, each step split
// into a multiply phase and then a compare phase in every cell.
// Drain: head cell gives one sorted index per unstalled cycle, n beats for n points.
// Reset clears control state; the coordinate store holds nothing until written.
// Depends on pasap_pkg, pasap_cell and polar_angle_sort_about_pivot_unit_macros.svh.
`default_nettype none
`include "polar_angle_sort_about_pivot_unit_macros.svh"
module polar_angle_sort_about_pivot_unit #(
  parameter int unsigned MAX_POINTS  = pasap_pkg::MaxPoints,
  parameter int unsigned COORD_WIDTH = pasap_pkg::CoordWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_coord_i,
  input  wire logic                          last_point_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pasap_pkg::IndexWidth-1:0]   point_index_o,
  output logic                               last_result_o
);
  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned IW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW      = $clog2(MAX_POINTS + 1);
  localparam int unsigned STEPS   = 2 * MAX_POINTS + 4;
  localparam int unsigned SW      = $clog2(STEPS);
  localparam int unsigned OW      = pasap_pkg::IndexWidth;

  pasap_pkg::state_e    state_q, state_d;
  pasap_pkg::cell_ctl_t ctl;

  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];
  logic signed [CW-1:0] rx_q, ry_q;

  logic [NW-1:0] load_cnt_q, n_q, rd_cnt_q, out_cnt_q;
  logic [SW-1:0] step_cnt_q;
  logic [IW-1:0] piv_slot_q;
  logic signed [CW-1:0] piv_x_q, piv_y_q;
  logic          phase_q;
  logic          in_acc, store_en, new_piv, emit, out_free, sort_done;

  // Feed stage one: offsets from the pivot
  logic                s1_v_q, s1_piv_q;
  logic [IW-1:0]       s1_idx_q;
  logic [CW-1:0]       s1_dx_q;
  logic signed [CW:0]  s1_dy_q;
  logic [CW:0]         s1_dymag;
  logic [2*CW:0]       s1_dist;
  logic signed [CW:0]  dx_full, dy_full;

  // Per-cell links; l* entry 0 is the feed, h* entry MAX_POINTS the empty tail
  logic               lv   [MAX_POINTS+1];
  logic [IW-1:0]      lidx [MAX_POINTS+1];
  logic               lpiv [MAX_POINTS+1];
  logic [CW-1:0]      ldx  [MAX_POINTS+1];
  logic signed [CW:0] ldy  [MAX_POINTS+1];
  logic [2*CW:0]      ldst [MAX_POINTS+1];
  logic               hv   [MAX_POINTS+1];
  logic [IW-1:0]      hidx [MAX_POINTS+1];
  logic               hpiv [MAX_POINTS+1];
  logic [CW-1:0]      hdx  [MAX_POINTS+1];
  logic signed [CW:0] hdy  [MAX_POINTS+1];
  logic [2*CW:0]      hdst [MAX_POINTS+1];

  logic          out_v_q, out_last_q;
  logic [IW-1:0] out_idx_q;
  logic [IW+OW-1:0] idx_wide;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pasap_pkg::ST_LOAD: begin
        if (in_acc && last_point_i) state_d = pasap_pkg::ST_SORT;
      end
      pasap_pkg::ST_SORT: begin
        if (sort_done) state_d = pasap_pkg::ST_DRAIN;
      end
      pasap_pkg::ST_DRAIN: begin
        if (emit && out_cnt_q == n_q - NW'(1)) state_d = pasap_pkg::ST_LOAD;
      end
      default: state_d = pasap_pkg::ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o  = 1'b1;
    ctl.prod_en = 1'b0;
    ctl.step    = 1'b0;
    ctl.shift   = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      pasap_pkg::ST_LOAD:  in_stall_o = 1'b0;
      pasap_pkg::ST_SORT: begin
        ctl.prod_en = !phase_q;
        ctl.step    = phase_q;
      end
      pasap_pkg::ST_DRAIN: begin
        emit      = out_free;
        ctl.shift = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign store_en  = in_acc && (load_cnt_q < NW'(MAX_POINTS));
  assign new_piv   = (load_cnt_q == '0) || (x_coord_i > piv_x_q) ||
                     (x_coord_i == piv_x_q && y_coord_i > piv_y_q);
  assign out_free  = !out_v_q || !out_stall_i;
  assign sort_done = ctl.step && step_cnt_q == SW'(STEPS - 1);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pasap_pkg::ST_LOAD;
      load_cnt_q <= '0;
      n_q        <= '0;
      rd_cnt_q   <= '0;
      step_cnt_q <= '0;
      out_cnt_q  <= '0;
      phase_q    <= 1'b0;
      piv_slot_q <= '0;
      piv_x_q    <= '0;
      piv_y_q    <= '0;
      s1_v_q     <= 1'b0;
      lv[0]      <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (store_en && new_piv) begin
        piv_slot_q <= load_cnt_q[IW-1:0];
        piv_x_q    <= x_coord_i;
        piv_y_q    <= y_coord_i;
      end
      // Start a sort: latch the set size, rewind the feed
      if (in_acc && last_point_i) begin
        n_q        <= store_en ? load_cnt_q + NW'(1) : load_cnt_q;
        load_cnt_q <= '0;
        rd_cnt_q   <= '0;
        step_cnt_q <= '0;
        phase_q    <= 1'b0;
        out_cnt_q  <= '0;
      end else if (store_en) begin
        load_cnt_q <= load_cnt_q + NW'(1);
      end
      if (state_q == pasap_pkg::ST_SORT) begin
        phase_q <= !phase_q;
      end
      // Advance the feed one point per step
      if (ctl.step) begin
        step_cnt_q <= step_cnt_q + SW'(1);
        s1_v_q     <= rd_cnt_q < n_q;
        lv[0]      <= s1_v_q;
        if (rd_cnt_q < NW'(MAX_POINTS)) rd_cnt_q <= rd_cnt_q + NW'(1);
      end
      // Output beat register
      if (emit) begin
        out_v_q   <= 1'b1;
        out_cnt_q <= out_cnt_q + NW'(1);
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Coordinate store, registered read
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_x[load_cnt_q[IW-1:0]] <= x_coord_i;
      mem_y[load_cnt_q[IW-1:0]] <= y_coord_i;
    end
    rx_q <= mem_x[rd_cnt_q[IW-1:0]];
    ry_q <= mem_y[rd_cnt_q[IW-1:0]];
  end

  // Offsets and squared distance
  always_comb begin
    dx_full  = (CW+1)'(piv_x_q) - (CW+1)'(rx_q);
    dy_full  = (CW+1)'(piv_y_q) - (CW+1)'(ry_q);
    s1_dymag = s1_dy_q[CW] ? (CW+1)'(-s1_dy_q) : (CW+1)'(s1_dy_q);
    s1_dist  = (2*CW+1)'(s1_dx_q) * (2*CW+1)'(s1_dx_q) +
               (2*CW+1)'(s1_dymag) * (2*CW+1)'(s1_dymag);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.step) begin
      s1_idx_q <= rd_cnt_q[IW-1:0];
      s1_piv_q <= rd_cnt_q[IW-1:0] == piv_slot_q;
      s1_dx_q  <= dx_full[CW-1:0];
      s1_dy_q  <= dy_full;
      lidx[0]  <= s1_idx_q;
      lpiv[0]  <= s1_piv_q;
      ldx[0]   <= s1_dx_q;
      ldy[0]   <= s1_dy_q;
      ldst[0]  <= s1_dist;
    end
    if (emit) begin
      out_idx_q  <= hidx[0];
      out_last_q <= out_cnt_q == n_q - NW'(1);
    end
  end

  // Empty tail beyond the last cell
  assign hv[MAX_POINTS]   = 1'b0;
  assign hidx[MAX_POINTS] = '0;
  assign hpiv[MAX_POINTS] = 1'b0;
  assign hdx[MAX_POINTS]  = '0;
  assign hdy[MAX_POINTS]  = '0;
  assign hdst[MAX_POINTS] = '0;

  // Row of sorting cells
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    pasap_cell #(.CW(CW), .IW(IW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .in_v_i     (lv[k]),
      .in_idx_i   (lidx[k]),
      .in_piv_i   (lpiv[k]),
      .in_dx_i    (ldx[k]),
      .in_dy_i    (ldy[k]),
      .in_dist_i  (ldst[k]),
      .nbr_v_i    (hv[k+1]),
      .nbr_idx_i  (hidx[k+1]),
      .nbr_piv_i  (hpiv[k+1]),
      .nbr_dx_i   (hdx[k+1]),
      .nbr_dy_i   (hdy[k+1]),
      .nbr_dist_i (hdst[k+1]),
      .pass_v_o   (lv[k+1]),
      .pass_idx_o (lidx[k+1]),
      .pass_piv_o (lpiv[k+1]),
      .pass_dx_o  (ldx[k+1]),
      .pass_dy_o  (ldy[k+1]),
      .pass_dist_o(ldst[k+1]),
      .held_v_o   (hv[k]),
      .held_idx_o (hidx[k]),
      .held_piv_o (hpiv[k]),
      .held_dx_o  (hdx[k]),
      .held_dy_o  (hdy[k]),
      .held_dist_o(hdst[k])
    );
  end

  assign idx_wide      = (IW+OW)'(out_idx_q);
  assign out_valid_o   = out_v_q;
  assign point_index_o = idx_wide[OW-1:0];
  assign last_result_o = out_last_q;

  `PASAP_ASSERT(a_cnt_bound, load_cnt_q <= NW'(MAX_POINTS))
  `PASAP_ASSERT_NEXT(a_last_ends_run, emit && out_cnt_q == n_q - NW'(1),
    state_q == pasap_pkg::ST_LOAD && out_last_q)
  `PASAP_ASSERT(a_beat_from_drain, $rose(out_v_q) |-> $past(state_q == pasap_pkg::ST_DRAIN))
  `PASAP_ASSERT(a_head_valid, emit |-> hv[0])
endmodule
`default_nettype wire

// ===== rtl/core/pasap_cell.sv =====
// One cell of the systolic insertion sorter: holds the best point seen so far
// and passes the other on. Depends on pasap_pkg.
`default_nettype none
module pasap_cell #(
  parameter int unsigned CW = pasap_pkg::CoordWidth,
  parameter int unsigned IW = $clog2(pasap_pkg::MaxPoints)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pasap_pkg::cell_ctl_t  ctl_i,
  input  wire logic                  in_v_i,
  input  wire logic [IW-1:0]         in_idx_i,
  input  wire logic                  in_piv_i,
  input  wire logic [CW-1:0]         in_dx_i,
  input  wire logic signed [CW:0]    in_dy_i,
  input  wire logic [2*CW:0]         in_dist_i,
  input  wire logic                  nbr_v_i,
  input  wire logic [IW-1:0]         nbr_idx_i,
  input  wire logic                  nbr_piv_i,
  input  wire logic [CW-1:0]         nbr_dx_i,
  input  wire logic signed [CW:0]    nbr_dy_i,
  input  wire logic [2*CW:0]         nbr_dist_i,
  output logic                       pass_v_o,
  output logic [IW-1:0]              pass_idx_o,
  output logic                       pass_piv_o,
  output logic [CW-1:0]              pass_dx_o,
  output logic signed [CW:0]         pass_dy_o,
  output logic [2*CW:0]              pass_dist_o,
  output logic                       held_v_o,
  output logic [IW-1:0]              held_idx_o,
  output logic                       held_piv_o,
  output logic [CW-1:0]              held_dx_o,
  output logic signed [CW:0]         held_dy_o,
  output logic [2*CW:0]              held_dist_o
);
  localparam int unsigned PW = 2 * CW + 2;

  logic                 hv_q, pv_q;
  logic [IW-1:0]        hidx_q, pidx_q;
  logic                 hpiv_q, ppiv_q;
  logic [CW-1:0]        hdx_q, pdx_q;
  logic signed [CW:0]   hdy_q, pdy_q;
  logic [2*CW:0]        hdist_q, pdist_q;
  logic signed [PW-1:0] ca_q, cb_q, ca_d, cb_d;
  logic                 in_ahead;
  logic                 dist_ahead;

  // Cross products for the slope compare, taken in the first half of a step
  always_comb begin
    ca_d = in_dy_i * $signed({1'b0, hdx_q});
    cb_d = hdy_q * $signed({1'b0, in_dx_i});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      ca_q <= ca_d;
      cb_q <= cb_d;
    end
  end

  // Rising distance, then arrival order on equal distance
  assign dist_ahead = (in_dist_i < hdist_q) ||
                      (in_dist_i == hdist_q && in_idx_i < hidx_q);

  // Strict order: incoming point goes ahead of the held one
  always_comb begin
    priority if (in_piv_i) begin
      in_ahead = !hpiv_q;
    end else if (hpiv_q) begin
      in_ahead = 1'b0;
    end else if (in_dx_i == '0 && hdx_q == '0) begin
      in_ahead = dist_ahead;
    end else if (in_dx_i == '0) begin
      in_ahead = 1'b1;
    end else if (hdx_q == '0) begin
      in_ahead = 1'b0;
    end else if (ca_q != cb_q) begin
      in_ahead = ca_q > cb_q;
    end else begin
      in_ahead = dist_ahead;
    end
  end

  // Valid flags of the held and passed slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      pv_q <= 1'b0;
    end else if (ctl_i.shift) begin
      hv_q <= nbr_v_i;
    end else if (ctl_i.step) begin
      if (in_v_i) begin
        hv_q <= 1'b1;
        pv_q <= hv_q;
      end else begin
        pv_q <= 1'b0;
      end
    end
  end

  // Payload: keep the earlier point, hand the later one right
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      hidx_q  <= nbr_idx_i;
      hpiv_q  <= nbr_piv_i;
      hdx_q   <= nbr_dx_i;
      hdy_q   <= nbr_dy_i;
      hdist_q <= nbr_dist_i;
    end else if (ctl_i.step && in_v_i) begin
      if (!hv_q || in_ahead) begin
        hidx_q  <= in_idx_i;
        hpiv_q  <= in_piv_i;
        hdx_q   <= in_dx_i;
        hdy_q   <= in_dy_i;
        hdist_q <= in_dist_i;
        pidx_q  <= hidx_q;
        ppiv_q  <= hpiv_q;
        pdx_q   <= hdx_q;
        pdy_q   <= hdy_q;
        pdist_q <= hdist_q;
      end else begin
        pidx_q  <= in_idx_i;
        ppiv_q  <= in_piv_i;
        pdx_q   <= in_dx_i;
        pdy_q   <= in_dy_i;
        pdist_q <= in_dist_i;
      end
    end
  end

  assign pass_v_o    = pv_q;
  assign pass_idx_o  = pidx_q;
  assign pass_piv_o  = ppiv_q;
  assign pass_dx_o   = pdx_q;
  assign pass_dy_o   = pdy_q;
  assign pass_dist_o = pdist_q;
  assign held_v_o    = hv_q;
  assign held_idx_o  = hidx_q;
  assign held_piv_o  = hpiv_q;
  assign held_dx_o   = hdx_q;
  assign held_dy_o   = hdy_q;
  assign held_dist_o = hdist_q;
endmodule
`default_nettype wire
